FILE: src/tphi_pkg.sv
// ----------------------------------------------------------------------------
// tphi_pkg
// Shared types and constants for the timed position history block.
// ----------------------------------------------------------------------------
package tphi_pkg;

  localparam int TIME_W = 32;
  localparam int POS_W  = 32;

  // Item selector codes
  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CAPTURE_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_HISTORY_SPAN     = 2'd1;
  localparam logic [1:0] CFG_AUTHORITY        = 2'd2;

  localparam logic [19:0] CAPTURE_INTERVAL_RST = 20'd16667;
  localparam logic [23:0] HISTORY_SPAN_RST     = 24'd1000000;

  typedef struct packed {
    logic [TIME_W-1:0]        t;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

endpackage

FILE: src/tphi_ram.sv
// ----------------------------------------------------------------------------
// tphi_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tphi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/timed_position_history_interp_unit.sv
// ----------------------------------------------------------------------------
// timed_position_history_interp_unit
// Ring of timestamped 3-D positions with periodic capture, age pruning and
// linear interpolation at a query time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_stall  | func, delta_time, now_time,
//          |           |                      | pos_x, pos_y, pos_z, query_time
//  out     | output    | out_valid / out_stall| out_x, out_y, out_z, captured,
//          |           |                      | frames_held
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item at a time. Begin: execute, then finish. Tick: likewise; a capture
//  adds a read and a check step per frame examined for pruning, plus one more
//  read when pruning stops at two frames. Sample: straight to finish on an
//  empty ring; first and last frame reads at span edges; else a scan through
//  the single frame-memory read port, bit-serial divide and interpolation.
//  Reset is synchronous and empties the ring; no memory clearing pass.
//  A finished result waits in the output register while a new item is taken;
//  the finish step holds only while that earlier result is still stalled.
// ----------------------------------------------------------------------------
module timed_position_history_interp_unit #(
  parameter int DEPTH     = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [19:0]                     delta_time,
  input  logic [tphi_pkg::TIME_W-1:0]     now_time,
  input  logic signed [tphi_pkg::POS_W-1:0] pos_x,
  input  logic signed [tphi_pkg::POS_W-1:0] pos_y,
  input  logic signed [tphi_pkg::POS_W-1:0] pos_z,
  input  logic [tphi_pkg::TIME_W-1:0]     query_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [tphi_pkg::POS_W-1:0] out_x,
  output logic signed [tphi_pkg::POS_W-1:0] out_y,
  output logic signed [tphi_pkg::POS_W-1:0] out_z,
  output logic                            captured,
  output logic [6:0]                      frames_held,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [23:0]                     cfg_data
);
  import tphi_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int DCW = $clog2(FRAC_BITS + 1);
  localparam int PW  = POS_W + FRAC_BITS + 3;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_EXEC   = 11'b00000000010,
    ST_PR_RD  = 11'b00000000100,
    ST_PR_CHK = 11'b00000001000,
    ST_SF     = 11'b00000010000,
    ST_SL     = 11'b00000100000,
    ST_SCAN   = 11'b00001000000,
    ST_DIV    = 11'b00010000000,
    ST_MUL    = 11'b00100000000,
    ST_ADD    = 11'b01000000000,
    ST_FIN    = 11'b10000000000
  } state_t;

  state_t state;

  // configuration
  logic [19:0] capture_interval;
  logic [23:0] history_span;
  logic        authority_enabled;

  // ring bookkeeping
  logic [AW-1:0] oldest;
  logic [CW-1:0] count;
  logic [31:0]   accum;

  // latched item
  logic [1:0]  it_func;
  logic [19:0] it_delta;
  frame_t      it_frame;
  logic [31:0] it_query;

  // work registers
  frame_t           ent_a;
  frame_t           ent_b;
  logic [CW-1:0]    idx;
  logic [32:0]      rem;
  logic [31:0]      den;
  logic [FRAC_BITS:0] frac;
  logic [DCW-1:0]   dcnt;
  logic [1:0]       axis;
  logic signed [PW-1:0] prod;
  logic signed [POS_W-1:0] res_x, res_y, res_z;
  logic             cap;

  // memory
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  frame_t        rd_data;
  logic [FRAME_W-1:0] rd_bits;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(k);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  logic in_xfer, out_xfer, full, fin_load;
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic signed [33:0] age;
  logic [31:0] num_w, den_w;
  logic [33:0] rem2;
  logic signed [POS_W-1:0] lerp_a, lerp_b;
  logic signed [POS_W:0]   lerp_d;
  logic signed [PW-1:0]    rnd;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign full     = (count == CW'(DEPTH));
  // load the output register once the previous result has left or is leaving
  assign fin_load = (state == ST_FIN) && (!out_valid || !out_stall);

  assign acc_sum = {1'b0, accum} + 33'(it_delta);
  assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign age     = $signed({2'b00, it_frame.t}) - $signed({2'b00, rd_data.t});
  assign num_w   = it_query - ent_a.t;
  assign den_w   = rd_data.t - ent_a.t;
  assign rem2    = {rem, 1'b0};

  always_comb begin
    case (axis)
      2'd0:    begin lerp_a = ent_a.x; lerp_b = ent_b.x; end
      2'd1:    begin lerp_a = ent_a.y; lerp_b = ent_b.y; end
      default: begin lerp_a = ent_a.z; lerp_b = ent_b.z; end
    endcase
  end
  assign lerp_d = (POS_W+1)'(lerp_b) - (POS_W+1)'(lerp_a);
  assign rnd    = (prod + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_comb begin
    we      = 1'b0;
    wr_addr = full ? oldest : slot_of(oldest, count);
    if (state == ST_EXEC && authority_enabled) begin
      if (it_func == FUNC_BEGIN) begin
        we = 1'b1;
      end else if (it_func == FUNC_TICK && acc_sat >= 32'(capture_interval)) begin
        we = 1'b1;
      end
    end
  end

  always_comb begin
    case (state)
      ST_SF:   rd_addr = slot_of(oldest, count - 1'b1);
      ST_SL:   rd_addr = slot_of(oldest, CW'(1));
      ST_SCAN: rd_addr = slot_of(oldest, idx + 1'b1);
      default: rd_addr = oldest;
    endcase
  end

  assign rd_data = frame_t'(rd_bits);

  tphi_ram #(.WIDTH(FRAME_W), .DEPTH(DEPTH)) u_frames (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (it_frame),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_interval  <= CAPTURE_INTERVAL_RST;
      history_span      <= HISTORY_SPAN_RST;
      authority_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAPTURE_INTERVAL: capture_interval  <= cfg_data[19:0];
        CFG_HISTORY_SPAN:     history_span      <= cfg_data;
        CFG_AUTHORITY:        authority_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_func  <= func;
      it_delta <= delta_time;
      it_frame <= '{t: now_time, x: pos_x, y: pos_y, z: pos_z};
      it_query <= query_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      oldest    <= '0;
      count     <= '0;
      accum     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cap <= we;
          if (we) begin
            if (full) begin
              oldest <= slot_inc(oldest);
            end else begin
              count <= count + 1'b1;
            end
          end
          if (it_func == FUNC_TICK && authority_enabled) begin
            accum <= we ? '0 : acc_sat;
          end
          if (it_func == FUNC_SAMPLE && count == '0) begin
            res_x <= it_frame.x;
            res_y <= it_frame.y;
            res_z <= it_frame.z;
          end else begin
            res_x <= '0;
            res_y <= '0;
            res_z <= '0;
          end
          if (it_func == FUNC_TICK && we) begin
            state <= ST_PR_RD;
          end else if (it_func == FUNC_SAMPLE && count != '0) begin
            state <= ST_SF;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_PR_RD: begin
          state <= (count > CW'(2)) ? ST_PR_CHK : ST_FIN;
        end
        ST_PR_CHK: begin
          // drop the oldest frame while it is beyond the span
          if (age > $signed({10'd0, history_span})) begin
            oldest <= slot_inc(oldest);
            count  <= count - 1'b1;
            state  <= ST_PR_RD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_SF: begin
          ent_a <= rd_data;
          state <= ST_SL;
        end
        ST_SL: begin
          if (it_query <= ent_a.t) begin
            res_x <= ent_a.x;
            res_y <= ent_a.y;
            res_z <= ent_a.z;
            state <= ST_FIN;
          end else if (it_query >= rd_data.t) begin
            res_x <= rd_data.x;
            res_y <= rd_data.y;
            res_z <= rd_data.z;
            state <= ST_FIN;
          end else begin
            idx   <= CW'(1);
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_data.t >= it_query) begin
            ent_b <= rd_data;
            rem   <= 33'(num_w);
            den   <= den_w;
            dcnt  <= '0;
            axis  <= 2'd0;
            if (num_w >= den_w) begin
              frac  <= (FRAC_BITS+1)'(1) << FRAC_BITS;
              state <= ST_MUL;
            end else begin
              frac  <= '0;
              state <= ST_DIV;
            end
          end else begin
            ent_a <= rd_data;
            idx   <= idx + 1'b1;
          end
        end
        ST_DIV: begin
          if (rem2 >= 34'(den)) begin
            rem  <= 33'(rem2 - 34'(den));
            frac <= {frac[FRAC_BITS-1:0], 1'b1};
          end else begin
            rem  <= rem2[32:0];
            frac <= {frac[FRAC_BITS-1:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(FRAC_BITS - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PW'(lerp_d) * PW'($signed({1'b0, frac}));
          state <= ST_ADD;
        end
        ST_ADD: begin
          case (axis)
            2'd0:    res_x <= lerp_a + rnd[POS_W-1:0];
            2'd1:    res_y <= lerp_a + rnd[POS_W-1:0];
            default: res_z <= lerp_a + rnd[POS_W-1:0];
          endcase
          if (axis == 2'd2) begin
            state <= ST_FIN;
          end else begin
            axis  <= axis + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (fin_load) begin
            out_x       <= res_x;
            out_y       <= res_y;
            out_z       <= res_z;
            captured    <= cap;
            frames_held <= 7'(count);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_EXEC)
    else $error("item taken while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("frame count beyond depth");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result shown outside finish");

  a_prune_floor: assert property (@(posedge clk) disable iff (rst)
    state == ST_PR_CHK |-> count > CW'(2))
    else $error("pruning below three frames");

endmodule

FILE: bench/timed_position_history_interp_check.sv
// ----------------------------------------------------------------------------
// timed_position_history_interp_check
// Watches the item, result and register channels of the position history
// block, keeps its own copy of the frame ring, predicts one result per item
// and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module timed_position_history_interp_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         func,
  input  logic [19:0]        delta_time,
  input  logic [31:0]        now_time,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0]        query_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               captured,
  input  logic [6:0]         frames_held,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 n_checked,
  output int                 n_fail
);
  timeunit 1ns;
  timeprecision 1ps;
  import tphi_pkg::*;

  localparam int RING = 64;
  localparam int FB   = 16;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               cap;
    logic [6:0]         held;
  } position_result_t;

  position_result_t pending_positions[$];

  logic [31:0] ring_t[RING];
  logic [31:0] ring_x[RING];
  logic [31:0] ring_y[RING];
  logic [31:0] ring_z[RING];
  int unsigned head;
  int unsigned held_cnt;
  logic [31:0] accum;
  logic [19:0] interval;
  logic [23:0] span;
  logic        auth;
  int          mism;
  int          done_cnt;

  function automatic int unsigned slot(int unsigned k);
    return (head + k) % RING;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint frac);
    longint sa;
    longint d;
    longint v;
    sa = longint'(signed'(a));
    d  = longint'(signed'(b)) - sa;
    v  = d * frac + (longint'(1) <<< (FB - 1));
    // arithmetic shift floors, matching round half up
    return 32'(sa + (v >>> FB));
  endfunction

  function automatic void store_frame(logic [31:0] t, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
    int unsigned s;
    if (held_cnt >= RING) begin
      s = head;
      head = (head + 1) % RING;
    end else begin
      s = slot(held_cnt);
      held_cnt++;
    end
    ring_t[s] = t;
    ring_x[s] = x;
    ring_y[s] = y;
    ring_z[s] = z;
  endfunction

  function automatic void drop_stale(logic [31:0] now);
    longint age;
    while (held_cnt > 2) begin
      age = longint'(now) - longint'(ring_t[head]);
      if (age <= longint'(span)) break;
      head = (head + 1) % RING;
      held_cnt--;
    end
  endfunction

  function automatic position_result_t predict_position(
      logic [1:0] f, logic [19:0] d, logic [31:0] now, logic [31:0] px,
      logic [31:0] py, logic [31:0] pz, logic [31:0] q);
    position_result_t r;
    longint sum;
    int unsigned first;
    int unsigned last;
    int unsigned sa;
    int unsigned sb;
    longint num;
    longint den;
    longint frac;
    bit found;
    r = '0;
    if (f == FUNC_BEGIN) begin
      if (auth) begin
        store_frame(now, px, py, pz);
        r.cap = 1'b1;
      end
    end else if (f == FUNC_TICK) begin
      if (auth) begin
        sum = longint'(accum) + longint'(d);
        accum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
        if (accum >= 32'(interval)) begin
          accum = '0;
          store_frame(now, px, py, pz);
          drop_stale(now);
          r.cap = 1'b1;
        end
      end
    end else if (f == FUNC_SAMPLE) begin
      if (held_cnt == 0) begin
        r.x = px;
        r.y = py;
        r.z = pz;
      end else begin
        first = slot(0);
        last  = slot(held_cnt - 1);
        if (q <= ring_t[first]) begin
          r.x = ring_x[first]; r.y = ring_y[first]; r.z = ring_z[first];
        end else if (q >= ring_t[last]) begin
          r.x = ring_x[last]; r.y = ring_y[last]; r.z = ring_z[last];
        end else begin
          found = 0;
          for (int unsigned i = 1; i < held_cnt && !found; i++) begin
            sb = slot(i);
            if (ring_t[sb] >= q) begin
              found = 1;
              sa = slot(i - 1);
              num = longint'(q) - longint'(ring_t[sa]);
              den = longint'(ring_t[sb]) - longint'(ring_t[sa]);
              if (den < 1) den = 1;
              if (num <= 0) frac = 0;
              else if (num >= den) frac = longint'(1) <<< FB;
              else frac = (num <<< FB) / den;
              r.x = blend(ring_x[sa], ring_x[sb], frac);
              r.y = blend(ring_y[sa], ring_y[sb], frac);
              r.z = blend(ring_z[sa], ring_z[sb], frac);
            end
          end
          if (!found) begin
            r.x = ring_x[last]; r.y = ring_y[last]; r.z = ring_z[last];
          end
        end
      end
    end
    r.held = 7'(held_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    position_result_t e;
    if (rst) begin
      pending_positions.delete();
      head = 0;
      held_cnt = 0;
      accum = '0;
      interval = CAPTURE_INTERVAL_RST;
      span = HISTORY_SPAN_RST;
      auth = 1'b1;
      mism = 0;
      done_cnt = 0;
    end else begin
      // results leave before the item that is taken at this same edge
      if (out_valid && !out_stall) begin
        if (pending_positions.size() == 0) begin
          mism++;
          if (mism <= 10) $display("%0t: result with nothing pending", $realtime);
        end else begin
          e = pending_positions.pop_front();
          done_cnt++;
          if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
              captured !== e.cap || frames_held !== e.held) begin
            mism++;
            if (mism <= 10)
              $display("%0t: mismatch exp x=%0d y=%0d z=%0d cap=%0b held=%0d got x=%0d y=%0d z=%0d cap=%0b held=%0d",
                       $realtime, e.x, e.y, e.z, e.cap, e.held,
                       out_x, out_y, out_z, captured, frames_held);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_positions.push_back(predict_position(func, delta_time, now_time,
                                                     pos_x, pos_y, pos_z, query_time));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAPTURE_INTERVAL) interval = cfg_data[19:0];
        else if (cfg_index == CFG_HISTORY_SPAN) span = cfg_data;
        else if (cfg_index == CFG_AUTHORITY) auth = cfg_data[0];
      end
    end
    n_checked <= done_cnt;
    n_fail    <= mism;
  end

endmodule

FILE: bench/timed_position_history_interp_unit_test.sv
// ----------------------------------------------------------------------------
// timed_position_history_interp_unit_test
// Drives directed and random begin, tick, sample and no-op items through the
// position history block under several register settings and idle patterns;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timed_position_history_interp_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tphi_pkg::*;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int PHASES = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = FUNC_BEGIN;
  logic [19:0]        delta_time = '0;
  logic [31:0]        now_time = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic [31:0]        query_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               captured;
  logic [6:0]         frames_held;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_CAPTURE_INTERVAL;
  logic [23:0]        cfg_data = '0;

  int n_checked;
  int n_fail;
  int n_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [31:0] cur_t = 32'd100000;
  logic signed [31:0] walk_x = '0;
  logic signed [31:0] walk_y = '0;
  logic signed [31:0] walk_z = '0;

  logic [19:0] ival_tab[PHASES] = '{20'd16667, 20'd0, 20'd1000000, 20'd5000,
                                    20'd2000, 20'd0, 20'd10000, 20'd1};
  logic [23:0] span_tab[PHASES] = '{24'd1000000, 24'd0, 24'd10000000, 24'd100000,
                                    24'd300000, 24'd50000, 24'd10000000, 24'd500000};
  logic        auth_tab[PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

  timed_position_history_interp_unit i_dut (.*);

  timed_position_history_interp_check i_check (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send(logic [1:0] f, logic [19:0] d, logic [31:0] nw, logic [31:0] x,
                      logic [31:0] y, logic [31:0] z, logic [31:0] q);
    func <= f;
    delta_time <= d;
    now_time <= nw;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    query_time <= q;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_checked != n_sent);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [1:0] f;
    logic [19:0] d;
    logic [31:0] nw;
    logic [31:0] q;
    r = $urandom_range(99);
    f = (r < 30) ? FUNC_BEGIN : (r < 60) ? FUNC_TICK : (r < 95) ? FUNC_SAMPLE : FUNC_NOP;
    // mostly advancing time; rare jumps anywhere
    if ($urandom_range(19) == 0) nw = $urandom;
    else begin
      cur_t = cur_t + $urandom_range(0, 40000);
      nw = cur_t;
    end
    if ($urandom_range(3) == 0) begin
      walk_x = $urandom; walk_y = $urandom; walk_z = $urandom;
    end else begin
      walk_x = walk_x + $signed($urandom_range(0, 2000)) - 1000;
      walk_y = walk_y + $signed($urandom_range(0, 2000)) - 1000;
      walk_z = walk_z + $signed($urandom_range(0, 2000)) - 1000;
    end
    d = ($urandom_range(9) == 0) ? 20'($urandom_range(0, 1000000))
                                 : 20'($urandom_range(0, 20000));
    if ($urandom_range(9) == 0) q = $urandom;
    else q = cur_t - $urandom_range(0, 1500000);
    send(f, d, nw, walk_x, walk_y, walk_z, q);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty ring, extremes, span edges, interpolation, future frame
    send(FUNC_SAMPLE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send(FUNC_NOP, 20'hFFFFF, 32'hFFFF_FFFF, 1, 2, 3, 32'hFFFF_FFFF);
    send(FUNC_BEGIN, 0, 1000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send(FUNC_BEGIN, 0, 2000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 0);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 1000);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 1001);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 1500);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 1999);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 2000);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send(FUNC_TICK, 0, 2500, 5, 6, 7, 0);
    send(FUNC_TICK, 20'd1000000, 3000, -5, -6, -7, 0);
    send(FUNC_BEGIN, 0, 32'hFFFF_FFF0, 9, 9, 9, 0);
    send(FUNC_TICK, 20'd1000000, 2_000_000, 11, 12, 13, 0);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 2_500_000);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 32'hFFFF_FFF8);
    for (int i = 0; i < 66; i++)
      send(FUNC_BEGIN, 0, 32'd3_000_000 + 32'(i) * 100, $urandom, $urandom, $urandom, 0);
    send(FUNC_SAMPLE, 0, 0, 0, 0, 0, 32'd3_003_050);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_CAPTURE_INTERVAL, 24'(ival_tab[p]));
      write_reg(CFG_HISTORY_SPAN, span_tab[p]);
      write_reg(CFG_AUTHORITY, 24'(auth_tab[p]));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      cur_t = cur_t + 32'd20_000_000;
      for (int i = 0; i < 100; i++) random_item();
      drain();
    end

    $display("Ran %0d items over %0d register settings with idle and stall phases.",
             n_sent, PHASES);
    $display("Checked %0d results, %0d mismatches.", n_checked, n_fail);
    if (n_fail == 0 && n_checked == n_sent) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
